### hw/rtl/pidaw_pkg.sv
package pidaw_pkg;

    // Data formats: signed Q16.16 data, Q32.16 integral
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int INTEG_W   = DATA_W + 16;
    localparam int TIME_W    = DATA_W - 1;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TAU = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measured;
        logic        [TIME_W-1:0] step_time;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
        logic                     integ_held;
    } out_beat_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_NONE    = 3'd0,
        MUL_KP_ERR  = 3'd1,
        MUL_KD_DIFF = 3'd2,
        MUL_TAU_D   = 3'd3,
        MUL_KI_DT   = 3'd4,
        MUL_G_ES    = 3'd5
    } mul_sel_t;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_LOAD      = 4'd1,
        ACT_PREP      = 4'd2,
        ACT_ES_SUM    = 4'd3,
        ACT_SAVE_P    = 4'd4,
        ACT_ACC_LOAD  = 4'd5,
        ACT_ACC_ADD   = 4'd6,
        ACT_DIV_ABS   = 4'd7,
        ACT_DIV_INIT  = 4'd8,
        ACT_DIV_STEP  = 4'd9,
        ACT_DIV_DONE  = 4'd10,
        ACT_OSUM      = 4'd11,
        ACT_HOLD_CHK  = 4'd12,
        ACT_INTEG_ADD = 4'd13,
        ACT_EMIT      = 4'd14
    } act_t;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        JMP_NEXT     = 3'd0,
        JMP_WAIT_IN  = 3'd1,
        JMP_DEN_ZERO = 3'd2,
        JMP_DIV_LOOP = 3'd3,
        JMP_HELD     = 3'd4,
        JMP_EMIT     = 3'd5
    } jmp_t;

    typedef struct packed {
        mul_sel_t        mul;
        act_t            act;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Program step addresses
    localparam logic [PC_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] ST_PREP     = 4'd1;
    localparam logic [PC_W-1:0] ST_MUL_P    = 4'd2;
    localparam logic [PC_W-1:0] ST_MUL_KD   = 4'd3;
    localparam logic [PC_W-1:0] ST_MUL_TD   = 4'd4;
    localparam logic [PC_W-1:0] ST_ACC      = 4'd5;
    localparam logic [PC_W-1:0] ST_ABS      = 4'd6;
    localparam logic [PC_W-1:0] ST_DIV_INIT = 4'd7;
    localparam logic [PC_W-1:0] ST_DIV_LOOP = 4'd8;
    localparam logic [PC_W-1:0] ST_DIV_DONE = 4'd9;
    localparam logic [PC_W-1:0] ST_OSUM1    = 4'd10;
    localparam logic [PC_W-1:0] ST_HOLD     = 4'd11;
    localparam logic [PC_W-1:0] ST_MUL_G    = 4'd12;
    localparam logic [PC_W-1:0] ST_INTEG    = 4'd13;
    localparam logic [PC_W-1:0] ST_OSUM2    = 4'd14;
    localparam logic [PC_W-1:0] ST_EMIT     = 4'd15;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{MUL_NONE, ACT_NONE, JMP_NEXT, ST_IDLE};
        unique case (pc)
            ST_IDLE:     w = '{MUL_NONE,    ACT_LOAD,      JMP_WAIT_IN,  ST_IDLE};
            ST_PREP:     w = '{MUL_NONE,    ACT_PREP,      JMP_NEXT,     ST_IDLE};
            ST_MUL_P:    w = '{MUL_KP_ERR,  ACT_ES_SUM,    JMP_NEXT,     ST_IDLE};
            ST_MUL_KD:   w = '{MUL_KD_DIFF, ACT_SAVE_P,    JMP_NEXT,     ST_IDLE};
            ST_MUL_TD:   w = '{MUL_TAU_D,   ACT_ACC_LOAD,  JMP_NEXT,     ST_IDLE};
            ST_ACC:      w = '{MUL_NONE,    ACT_ACC_ADD,   JMP_DEN_ZERO, ST_OSUM1};
            ST_ABS:      w = '{MUL_NONE,    ACT_DIV_ABS,   JMP_NEXT,     ST_IDLE};
            ST_DIV_INIT: w = '{MUL_NONE,    ACT_DIV_INIT,  JMP_NEXT,     ST_IDLE};
            ST_DIV_LOOP: w = '{MUL_NONE,    ACT_DIV_STEP,  JMP_DIV_LOOP, ST_DIV_LOOP};
            ST_DIV_DONE: w = '{MUL_NONE,    ACT_DIV_DONE,  JMP_NEXT,     ST_IDLE};
            ST_OSUM1:    w = '{MUL_KI_DT,   ACT_OSUM,      JMP_NEXT,     ST_IDLE};
            ST_HOLD:     w = '{MUL_NONE,    ACT_HOLD_CHK,  JMP_NEXT,     ST_IDLE};
            ST_MUL_G:    w = '{MUL_G_ES,    ACT_NONE,      JMP_HELD,     ST_EMIT};
            ST_INTEG:    w = '{MUL_NONE,    ACT_INTEG_ADD, JMP_NEXT,     ST_IDLE};
            ST_OSUM2:    w = '{MUL_NONE,    ACT_OSUM,      JMP_NEXT,     ST_IDLE};
            ST_EMIT:     w = '{MUL_NONE,    ACT_EMIT,      JMP_EMIT,     ST_IDLE};
            default:     w = '{MUL_NONE,    ACT_NONE,      JMP_NEXT,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/pid_antiwindup_filtered_derivative.sv
// PID controller with conditional integration and a filtered derivative on
// measurement, signed Q16.16 data, Q32.16 integral.
// Input channel in_valid/in_ready/in_data carries setpoint, measured and
// step_time; output channel out_valid/out_ready/out_data carries drive,
// clamped and integ_held, one result beat per input beat.
// Gains, filter time constant and limits are set through cfg_write, cfg_index
// and cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. Unknown indexes are ignored. A control store
// steps one 33x33 multiplier, an adder datapath and a restoring divider that
// makes one quotient bit per cycle. The divide is skipped when 2*tau + dt is
// zero, and the integral update is skipped when the integral is held.
// A new input beat is accepted only once the previous one has been emitted.
// The result sits in an output register; the next input beat is accepted
// while it waits. If the receiver stalls with a result still pending, the
// sequencer waits at its last step until the output register frees up.
// Reset clears the integral, derivative and history state, zeroes the gains
// and time constant, and opens the limits to the full data range.
module pid_antiwindup_filtered_derivative (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  pidaw_pkg::in_beat_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pidaw_pkg::out_beat_t                  out_data,
    input  logic                                  cfg_write,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidaw_pkg::DATA_W-1:0]          cfg_data
);

    localparam int DATA_W  = pidaw_pkg::DATA_W;
    localparam int FRAC_W  = pidaw_pkg::FRAC_W;
    localparam int INTEG_W = pidaw_pkg::INTEG_W;
    localparam int TIME_W  = pidaw_pkg::TIME_W;
    localparam int PC_W    = pidaw_pkg::PC_W;
    localparam int MUL_W   = DATA_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DEN_W   = DATA_W + 1;
    localparam int OSUM_W  = INTEG_W + 2;
    localparam int CNT_W   = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // Saturate a product-wide value to the data width
    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}})
            r = v[DATA_W-1:0];
        else if (v[PROD_W-1])
            r = DATA_MIN;
        else
            r = DATA_MAX;
        return r;
    endfunction

    // Saturate a product-wide value to the integral width
    function automatic logic signed [INTEG_W-1:0] sat_integ(
        input logic signed [PROD_W-1:0] v);
        logic signed [INTEG_W-1:0] r;
        if (v[PROD_W-1:INTEG_W-1] == {(PROD_W-INTEG_W+1){v[PROD_W-1]}})
            r = v[INTEG_W-1:0];
        else if (v[PROD_W-1])
            r = {1'b1, {(INTEG_W-1){1'b0}}};
        else
            r = {1'b0, {(INTEG_W-1){1'b1}}};
        return r;
    endfunction

    // Configuration registers
    logic signed [DATA_W-1:0]  kp_reg;
    logic signed [DATA_W-1:0]  ki_reg;
    logic signed [DATA_W-1:0]  kd_reg;
    logic        [TIME_W-1:0]  tau_reg;
    logic signed [DATA_W-1:0]  lim_lo_reg;
    logic signed [DATA_W-1:0]  lim_hi_reg;

    // Controller state
    logic signed [INTEG_W-1:0] integ_reg,     integ_next;
    logic signed [DATA_W-1:0]  last_err_reg,  last_err_next;
    logic signed [DATA_W-1:0]  deriv_reg,     deriv_next;
    logic signed [DATA_W-1:0]  last_meas_reg, last_meas_next;

    // Sequencer
    logic [PC_W-1:0]           pc_reg, pc_next;
    pidaw_pkg::ucode_t         uc;

    // Working registers
    pidaw_pkg::in_beat_t       in_reg,   in_next;
    logic signed [DATA_W-1:0]  err_reg,  err_next;
    logic signed [MUL_W-1:0]   diff_reg, diff_next;
    logic signed [MUL_W-1:0]   tdiff_reg, tdiff_next;
    logic        [DEN_W-1:0]   den_reg,  den_next;
    logic signed [MUL_W-1:0]   es_reg,   es_next;
    logic signed [DATA_W-1:0]  p_reg,    p_next;
    logic signed [DATA_W-1:0]  g_reg,    g_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  acc_reg,  acc_next;
    logic        [DEN_W-1:0]   rem_reg,  rem_next;
    logic        [DATA_W-1:0]  quo_reg,  quo_next;
    logic        [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic                      neg_reg,  neg_next;
    logic                      ovf_reg,  ovf_next;
    logic signed [OSUM_W-1:0]  osum_reg, osum_next;
    logic                      held_reg, held_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    pidaw_pkg::out_beat_t      out_data_reg,  out_data_next;

    // Combinational helpers
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [DATA_W:0]    err_wide;
    logic        [DEN_W:0]     div_trial;
    logic        [DEN_W:0]     div_sub;
    logic signed [PROD_W-1:0]  integ_sum;
    logic                      err_pos;
    logic                      in_fire;
    logic                      slot_free;
    logic                      emit_fire;

    // Control word fetch and handshakes
    assign uc        = pidaw_pkg::ucode_rom(pc_reg);
    assign in_ready  = (uc.jmp == pidaw_pkg::JMP_WAIT_IN);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_fire = (uc.act == pidaw_pkg::ACT_EMIT) && slot_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Step counter and branches
    always_comb
    begin
        unique case (uc.jmp)
            pidaw_pkg::JMP_NEXT:
                pc_next = pc_reg + 1'b1;
            pidaw_pkg::JMP_WAIT_IN:
                pc_next = in_fire ? pc_reg + 1'b1 : pc_reg;
            pidaw_pkg::JMP_DEN_ZERO:
                pc_next = (den_reg == '0) ? uc.target : pc_reg + 1'b1;
            pidaw_pkg::JMP_DIV_LOOP:
                pc_next = (cnt_reg != CNT_LAST) ? uc.target : pc_reg + 1'b1;
            pidaw_pkg::JMP_HELD:
                pc_next = held_reg ? uc.target : pc_reg + 1'b1;
            pidaw_pkg::JMP_EMIT:
                pc_next = slot_free ? uc.target : pc_reg;
            default:
                pc_next = pidaw_pkg::ST_IDLE;
        endcase
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uc.mul)
            pidaw_pkg::MUL_KP_ERR:
            begin
                mul_a = MUL_W'(kp_reg);
                mul_b = MUL_W'(err_reg);
            end
            pidaw_pkg::MUL_KD_DIFF:
            begin
                mul_a = MUL_W'(kd_reg);
                mul_b = diff_reg;
            end
            pidaw_pkg::MUL_TAU_D:
            begin
                mul_a = tdiff_reg;
                mul_b = MUL_W'(deriv_reg);
            end
            pidaw_pkg::MUL_KI_DT:
            begin
                mul_a = MUL_W'(ki_reg);
                mul_b = $signed({2'b00, in_reg.step_time});
            end
            pidaw_pkg::MUL_G_ES:
            begin
                mul_a = MUL_W'(g_reg);
                mul_b = es_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath helpers
    assign err_wide  = (DATA_W+1)'(in_reg.setpoint) - (DATA_W+1)'(in_reg.measured);
    assign div_trial = {rem_reg, quo_reg[DATA_W-1]};
    assign div_sub   = div_trial - {1'b0, den_reg};
    assign integ_sum = PROD_W'(integ_reg) + (prod_reg >>> FRAC_W);
    assign err_pos   = !err_reg[DATA_W-1] && (err_reg != '0);

    // Datapath actions
    always_comb
    begin
        in_next        = in_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        tdiff_next     = tdiff_reg;
        den_next       = den_reg;
        es_next        = es_reg;
        p_next         = p_reg;
        g_next         = g_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        ovf_next       = ovf_reg;
        osum_next      = osum_reg;
        held_next      = held_reg;
        integ_next     = integ_reg;
        last_err_next  = last_err_reg;
        deriv_next     = deriv_reg;
        last_meas_next = last_meas_reg;
        out_data_next  = out_data_reg;
        prod_next      = (uc.mul != pidaw_pkg::MUL_NONE) ? mul_a * mul_b : prod_reg;

        unique case (uc.act)
            pidaw_pkg::ACT_NONE:
            begin
                held_next = held_reg;
            end
            pidaw_pkg::ACT_LOAD:
            begin
                if (in_fire)
                    in_next = in_data;
            end
            // error, measurement step, 2*tau - dt and 2*tau + dt
            pidaw_pkg::ACT_PREP:
            begin
                err_next   = sat_data(PROD_W'(err_wide));
                diff_next  = MUL_W'(in_reg.measured) - MUL_W'(last_meas_reg);
                tdiff_next = $signed({1'b0, tau_reg, 1'b0})
                           - $signed({2'b00, in_reg.step_time});
                den_next   = {1'b0, tau_reg, 1'b0} + {2'b00, in_reg.step_time};
            end
            pidaw_pkg::ACT_ES_SUM:
            begin
                es_next = MUL_W'(err_reg) + MUL_W'(last_err_reg);
            end
            pidaw_pkg::ACT_SAVE_P:
            begin
                p_next = sat_data(prod_reg >>> FRAC_W);
            end
            pidaw_pkg::ACT_ACC_LOAD:
            begin
                acc_next = prod_reg <<< 1;
            end
            pidaw_pkg::ACT_ACC_ADD:
            begin
                acc_next = acc_reg + prod_reg;
            end
            pidaw_pkg::ACT_DIV_ABS:
            begin
                neg_next = acc_reg[PROD_W-1];
                acc_next = acc_reg[PROD_W-1] ? -acc_reg : acc_reg;
            end
            // quotient of 2^DATA_W or more always saturates
            pidaw_pkg::ACT_DIV_INIT:
            begin
                ovf_next = (acc_reg[2*DATA_W:DATA_W] >= den_reg);
                rem_next = acc_reg[2*DATA_W:DATA_W];
                quo_next = acc_reg[DATA_W-1:0];
                cnt_next = '0;
            end
            // restoring divide, one quotient bit per step
            pidaw_pkg::ACT_DIV_STEP:
            begin
                if (!div_sub[DEN_W])
                begin
                    rem_next = div_sub[DEN_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_trial[DEN_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            // filter output is the negated quotient, saturated
            pidaw_pkg::ACT_DIV_DONE:
            begin
                if (neg_reg)
                    deriv_next = (ovf_reg || quo_reg[DATA_W-1]) ? DATA_MAX : $signed(quo_reg);
                else if (ovf_reg || (quo_reg[DATA_W-1] && (quo_reg[DATA_W-2:0] != '0)))
                    deriv_next = DATA_MIN;
                else
                    deriv_next = -$signed(quo_reg);
            end
            pidaw_pkg::ACT_OSUM:
            begin
                osum_next = OSUM_W'(p_reg) + OSUM_W'(integ_reg) + OSUM_W'(deriv_reg);
            end
            // hold the integral when pushing further into a limit
            pidaw_pkg::ACT_HOLD_CHK:
            begin
                held_next = ((osum_reg > OSUM_W'(lim_hi_reg)) && err_pos)
                         || ((osum_reg < OSUM_W'(lim_lo_reg)) && err_reg[DATA_W-1]);
                g_next    = sat_data(prod_reg >>> (FRAC_W + 1));
            end
            pidaw_pkg::ACT_INTEG_ADD:
            begin
                integ_next = sat_integ(integ_sum);
            end
            // clamp, write the output register, advance history
            pidaw_pkg::ACT_EMIT:
            begin
                if (emit_fire)
                begin
                    if (osum_reg > OSUM_W'(lim_hi_reg))
                    begin
                        out_data_next.drive   = lim_hi_reg;
                        out_data_next.clamped = 1'b1;
                    end
                    else if (osum_reg < OSUM_W'(lim_lo_reg))
                    begin
                        out_data_next.drive   = lim_lo_reg;
                        out_data_next.clamped = 1'b1;
                    end
                    else
                    begin
                        out_data_next.drive   = osum_reg[DATA_W-1:0];
                        out_data_next.clamped = 1'b0;
                    end
                    out_data_next.integ_held = held_reg;
                    last_err_next  = err_reg;
                    last_meas_next = in_reg.measured;
                end
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= pidaw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            tau_reg       <= '0;
            lim_lo_reg    <= DATA_MIN;
            lim_hi_reg    <= DATA_MAX;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            deriv_reg     <= '0;
            last_meas_reg <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            last_err_reg  <= last_err_next;
            deriv_reg     <= deriv_next;
            last_meas_reg <= last_meas_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pidaw_pkg::CFG_PROP_GAIN:  kp_reg     <= cfg_data;
                    pidaw_pkg::CFG_INTEG_GAIN: ki_reg     <= cfg_data;
                    pidaw_pkg::CFG_DERIV_GAIN: kd_reg     <= cfg_data;
                    pidaw_pkg::CFG_FILTER_TAU: tau_reg    <= cfg_data[TIME_W-1:0];
                    pidaw_pkg::CFG_LIMIT_LOW:  lim_lo_reg <= cfg_data;
                    pidaw_pkg::CFG_LIMIT_HIGH: lim_hi_reg <= cfg_data;
                    default:                   kp_reg     <= kp_reg;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        err_reg      <= err_next;
        diff_reg     <= diff_next;
        tdiff_reg    <= tdiff_next;
        den_reg      <= den_next;
        es_reg       <= es_next;
        p_reg        <= p_next;
        g_reg        <= g_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        ovf_reg      <= ovf_next;
        osum_reg     <= osum_next;
        held_reg     <= held_next;
        out_data_reg <= out_data_next;
    end

    // Accepted beat always starts the program
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> pc_reg == pidaw_pkg::ST_PREP)
        else $error("accepted input did not start the program");

    // Results appear only from the last step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pc_reg) == pidaw_pkg::ST_EMIT)
        else $error("output valid raised outside the emit step");

    // Divide finishes only after the full bit count
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == pidaw_pkg::ST_DIV_DONE |->
            $past(pc_reg) == pidaw_pkg::ST_DIV_LOOP && $past(cnt_reg) == CNT_LAST)
        else $error("divide ended early");

    // Integration never runs when held
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == pidaw_pkg::ST_INTEG |-> !held_reg)
        else $error("integral updated while held");

endmodule
